// ===== hw/rtl/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared constants, state type and controller/datapath interface structs for
// the bitmask dynamic-programming tour solver.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int MAX_V = 12;
  localparam int WB    = 16;
  localparam int TCW   = 20;
  localparam int VW    = $clog2(MAX_V);
  localparam int NW    = $clog2(MAX_V + 1);
  localparam int SW    = MAX_V;
  localparam int CELLS = (1 << MAX_V) * MAX_V;
  localparam int CAW   = $clog2(CELLS);
  localparam int WAW   = $clog2(MAX_V * MAX_V);
  localparam longint MAXC = longint'(MAX_V) * ((longint'(1) << WB) - 1);
  localparam int CW    = $clog2(MAXC + 1);
  localparam int EW    = CW + VW + 1;
  localparam int VC_RESET = 4;

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_CELL, S_RED, S_DRAIN, S_WRC, S_FIN, S_FRED,
    S_FDRAIN, S_FDEC, S_TBR, S_TBW, S_EMIT
  } state_t;

  typedef struct packed {
    logic load_we;
    logic start;
    logic cell_wr;
    logic cell_next;
    logic red_start;
    logic fin_start;
    logic red_issue;
    logic tb_start;
    logic tb_rd;
    logic tb_wt;
    logic not_found;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic k_last;
    logic cell_last;
    logic acc_v;
    logic n_one;
    logic pos_one;
    logic epos_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== hw/rtl/tsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsp_ctrl
// Sequencer for loading, the subset table sweep, the closing search, the
// traceback and the result words.
// ----------------------------------------------------------------------------
module tsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_stall,
  input  tsp_pkg::sts_t sts,
  output tsp_pkg::cmd_t cmd
);

  tsp_pkg::state_t state_r, state_nxt;
  logic acc;

  assign in_stall = (state_r != tsp_pkg::S_LOAD);
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsp_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      tsp_pkg::S_LOAD: begin
        if (acc) begin
          cmd.load_we = 1'b1;
          if (in_last) begin
            cmd.start = 1'b1;
            state_nxt = tsp_pkg::S_START;
          end
        end
      end
      tsp_pkg::S_START: begin
        state_nxt = sts.n_one ? tsp_pkg::S_EMIT : tsp_pkg::S_CELL;
      end
      tsp_pkg::S_CELL: begin
        if (sts.trivial) begin
          cmd.cell_wr   = 1'b1;
          cmd.cell_next = 1'b1;
        end else begin
          cmd.red_start = 1'b1;
          state_nxt     = tsp_pkg::S_RED;
        end
      end
      tsp_pkg::S_RED: begin
        cmd.red_issue = 1'b1;
        if (sts.k_last) begin
          state_nxt = tsp_pkg::S_DRAIN;
        end
      end
      tsp_pkg::S_DRAIN: begin
        state_nxt = tsp_pkg::S_WRC;
      end
      tsp_pkg::S_WRC: begin
        cmd.cell_wr   = 1'b1;
        cmd.cell_next = 1'b1;
        state_nxt     = sts.cell_last ? tsp_pkg::S_FIN : tsp_pkg::S_CELL;
      end
      tsp_pkg::S_FIN: begin
        cmd.fin_start = 1'b1;
        state_nxt     = tsp_pkg::S_FRED;
      end
      tsp_pkg::S_FRED: begin
        cmd.red_issue = 1'b1;
        if (sts.k_last) begin
          state_nxt = tsp_pkg::S_FDRAIN;
        end
      end
      tsp_pkg::S_FDRAIN: begin
        state_nxt = tsp_pkg::S_FDEC;
      end
      tsp_pkg::S_FDEC: begin
        if (sts.acc_v) begin
          cmd.tb_start = 1'b1;
          state_nxt    = tsp_pkg::S_TBR;
        end else begin
          cmd.not_found = 1'b1;
          state_nxt     = tsp_pkg::S_EMIT;
        end
      end
      tsp_pkg::S_TBR: begin
        cmd.tb_rd = 1'b1;
        state_nxt = tsp_pkg::S_TBW;
      end
      tsp_pkg::S_TBW: begin
        cmd.tb_wt = 1'b1;
        state_nxt = sts.pos_one ? tsp_pkg::S_EMIT : tsp_pkg::S_TBR;
      end
      tsp_pkg::S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit_load = 1'b1;
          if (sts.epos_last) begin
            state_nxt = tsp_pkg::S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = tsp_pkg::S_LOAD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tsp_datapath.sv =====
// ----------------------------------------------------------------------------
// tsp_datapath
// Weight store, cost/predecessor table, subset and vertex counters, the
// min-reduction unit, tour buffer and result word register.
// ----------------------------------------------------------------------------
module tsp_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [3:0]               cfg_wr_data,
  input  logic [3:0]               in_row,
  input  logic [3:0]               in_col,
  input  logic [15:0]              in_weight,
  input  tsp_pkg::cmd_t            cmd,
  output tsp_pkg::sts_t            sts,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [3:0]               out_vertex,
  output logic [19:0]              out_tour_cost,
  output logic                     out_found,
  output logic                     out_end_of_tour
);

  logic [3:0]               vc_r;
  logic [tsp_pkg::NW-1:0]   n_r;
  logic [tsp_pkg::SW-1:0]   mask_r, prev_r;
  logic [tsp_pkg::VW-1:0]   j_r, dest_r, k_r, k_d_r, acc_k_r, pos_r, epos_r;
  logic                     v_d_r, acc_v_r, found_r;
  logic [tsp_pkg::CW-1:0]   acc_c_r, best_r;
  logic [tsp_pkg::VW-1:0]   tour_r [tsp_pkg::MAX_V];
  logic [tsp_pkg::WB-1:0]   wmem [tsp_pkg::MAX_V * tsp_pkg::MAX_V];
  logic [tsp_pkg::WB-1:0]   wrd_r;
  logic [tsp_pkg::EW-1:0]   cmem [tsp_pkg::CELLS];
  logic [tsp_pkg::EW-1:0]   crd_r;
  logic                     ov_r, ofound_r, oeot_r;
  logic [3:0]               overt_r;
  logic [19:0]              ocost_r;

  logic [tsp_pkg::NW-1:0]   n_clamp;
  logic [tsp_pkg::SW-1:0]   full_w, jbit;
  logic [tsp_pkg::VW-1:0]   nm1;
  logic [tsp_pkg::WAW-1:0]  wa_ld, wa_rd;
  logic [tsp_pkg::CAW-1:0]  ca_cell, ca_red, ca_rd;
  logic                     ld_ok, trivial, c_valid, cand_ok, upd;
  logic [tsp_pkg::VW-1:0]   c_pred;
  logic [tsp_pkg::CW-1:0]   c_cost, cand;
  logic [tsp_pkg::EW-1:0]   cw_data;

  always_comb begin
    if (vc_r == 4'd0) begin
      n_clamp = tsp_pkg::NW'(1);
    end else if (32'(vc_r) > tsp_pkg::MAX_V) begin
      n_clamp = tsp_pkg::NW'(tsp_pkg::MAX_V);
    end else begin
      n_clamp = tsp_pkg::NW'(vc_r);
    end
  end

  assign nm1     = tsp_pkg::VW'(n_r - tsp_pkg::NW'(1));
  assign full_w  = ~({tsp_pkg::SW{1'b1}} << n_r);
  assign jbit    = tsp_pkg::SW'(1) << j_r;
  assign ld_ok   = (32'(in_row) < tsp_pkg::MAX_V) && (32'(in_col) < tsp_pkg::MAX_V);
  assign wa_ld   = tsp_pkg::WAW'(in_row) * tsp_pkg::WAW'(tsp_pkg::MAX_V)
                   + tsp_pkg::WAW'(in_col);
  assign wa_rd   = tsp_pkg::WAW'(k_r) * tsp_pkg::WAW'(tsp_pkg::MAX_V)
                   + tsp_pkg::WAW'(dest_r);
  assign ca_cell = tsp_pkg::CAW'(mask_r) * tsp_pkg::CAW'(tsp_pkg::MAX_V)
                   + tsp_pkg::CAW'(j_r);
  assign ca_red  = tsp_pkg::CAW'(prev_r) * tsp_pkg::CAW'(tsp_pkg::MAX_V)
                   + tsp_pkg::CAW'(k_r);
  assign ca_rd   = cmd.tb_rd ? ca_cell : ca_red;
  assign trivial = (j_r == '0) || !mask_r[j_r];

  assign c_valid = crd_r[tsp_pkg::EW-1];
  assign c_pred  = crd_r[tsp_pkg::CW +: tsp_pkg::VW];
  assign c_cost  = crd_r[tsp_pkg::CW-1:0];
  assign cand    = c_cost + tsp_pkg::CW'(wrd_r);
  assign cand_ok = v_d_r && prev_r[k_d_r] && c_valid && (k_d_r != dest_r)
                   && (wrd_r != '0);
  assign upd     = cand_ok && (!acc_v_r || (cand < acc_c_r));
  assign cw_data = trivial ? {(j_r == '0) && (mask_r == tsp_pkg::SW'(1)),
                              tsp_pkg::VW'(0), tsp_pkg::CW'(0)}
                           : {acc_v_r, acc_k_r, acc_c_r};

  always_ff @(posedge clk) begin
    if (cmd.load_we && ld_ok) begin
      wmem[wa_ld] <= tsp_pkg::WB'(in_weight);
    end
    wrd_r <= wmem[wa_rd];
    if (cmd.cell_wr) begin
      cmem[ca_cell] <= cw_data;
    end
    crd_r <= cmem[ca_rd];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r    <= 4'(tsp_pkg::VC_RESET);
      v_d_r   <= 1'b0;
      acc_v_r <= 1'b0;
      found_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vc_r <= cfg_wr_data;
      end
      v_d_r <= cmd.red_issue;
      if (cmd.red_start || cmd.fin_start) begin
        acc_v_r <= 1'b0;
      end else if (upd) begin
        acc_v_r <= 1'b1;
      end
      if (cmd.start || cmd.tb_start) begin
        found_r <= 1'b1;
      end else if (cmd.not_found) begin
        found_r <= 1'b0;
      end
      if (cmd.emit_load) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_d_r <= k_r;
    if (upd) begin
      acc_c_r <= cand;
      acc_k_r <= k_d_r;
    end
    if (cmd.start) begin
      n_r    <= n_clamp;
      mask_r <= tsp_pkg::SW'(1);
      j_r    <= '0;
      best_r <= '0;
      epos_r <= '0;
    end
    if (cmd.cell_next) begin
      if (j_r == nm1) begin
        j_r    <= '0;
        mask_r <= mask_r + tsp_pkg::SW'(2);
      end else begin
        j_r <= j_r + tsp_pkg::VW'(1);
      end
    end
    if (cmd.red_start) begin
      prev_r <= mask_r & ~jbit;
      dest_r <= j_r;
      k_r    <= '0;
    end
    if (cmd.fin_start) begin
      prev_r <= full_w;
      dest_r <= '0;
      k_r    <= '0;
    end
    if (cmd.red_issue) begin
      k_r <= k_r + tsp_pkg::VW'(1);
    end
    if (cmd.tb_start) begin
      best_r <= acc_c_r;
      j_r    <= acc_k_r;
      mask_r <= full_w;
      pos_r  <= nm1;
    end
    if (cmd.not_found) begin
      best_r <= '0;
    end
    if (cmd.tb_rd) begin
      tour_r[pos_r] <= j_r;
      mask_r        <= mask_r & ~jbit;
    end
    if (cmd.tb_wt) begin
      j_r   <= c_pred;
      pos_r <= pos_r - tsp_pkg::VW'(1);
    end
    if (cmd.emit_load) begin
      overt_r  <= ((epos_r == '0) || !found_r) ? 4'd0 : 4'(tour_r[epos_r]);
      ocost_r  <= tsp_pkg::TCW'(best_r);
      ofound_r <= found_r;
      oeot_r   <= sts.epos_last;
      epos_r   <= epos_r + tsp_pkg::VW'(1);
    end
  end

  always_comb begin
    sts           = '0;
    sts.trivial   = trivial;
    sts.k_last    = (k_r == nm1);
    sts.cell_last = (mask_r == full_w) && (j_r == nm1);
    sts.acc_v     = acc_v_r;
    sts.n_one     = (n_r == tsp_pkg::NW'(1));
    sts.pos_one   = (pos_r == tsp_pkg::VW'(1));
    sts.epos_last = !found_r || (epos_r == nm1);
    sts.out_busy  = ov_r && out_stall;
  end

  assign out_valid       = ov_r;
  assign out_vertex      = overt_r;
  assign out_tour_cost   = ocost_r;
  assign out_found       = ofound_r;
  assign out_end_of_tour = oeot_r;

  a_kd_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_d_r |-> (32'(k_d_r) < 32'(n_r)))
    else $error("reduction index beyond vertex count");
  a_tb_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tb_start |=> found_r)
    else $error("traceback started without a found tour");
  a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && sts.epos_last) |=> (ov_r && oeot_r))
    else $error("final word not marked end of tour");

endmodule

// ===== hw/rtl/tsp_bitmask_dp_solver_top.sv =====
// ----------------------------------------------------------------------------
// tsp_bitmask_dp_solver_top
// Exact closed-tour solver over a loaded weight matrix using subset-bitmask
// dynamic programming, with a sequencer and a separate datapath.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_row, in_col, in_weight, in_last
//   out      output     out_valid/out_stall out_vertex, out_tour_cost,
//                                          out_found, out_end_of_tour
//   cfg      input      cfg_wr_en          cfg_wr_data (vertex count)
//
// Matrix words are taken only in S_LOAD. A solve visits 2^(N-1) * N table cells;
// one whose end vertex (not 0) is in its subset goes via S_RED, S_DRAIN, S_WRC;
// any other is written in S_CELL. The closing search runs S_FIN to S_FDEC, then
// traceback S_TBR, S_TBW per vertex after 0; a word per vertex (one if no tour).
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result word holds, and the solver waits in place for it.
// ----------------------------------------------------------------------------
module tsp_bitmask_dp_solver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_row,
  input  logic [3:0]  in_col,
  input  logic [15:0] in_weight,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_vertex,
  output logic [19:0] out_tour_cost,
  output logic        out_found,
  output logic        out_end_of_tour
);

  tsp_pkg::cmd_t cmd;
  tsp_pkg::sts_t sts;

  tsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsp_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_weight       (in_weight),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_vertex      (out_vertex),
    .out_tour_cost   (out_tour_cost),
    .out_found       (out_found),
    .out_end_of_tour (out_end_of_tour)
  );

endmodule

// ===== sim/tb_tsp_bitmask_dp_solver_top.sv =====
// ----------------------------------------------------------------------------
// tb_tsp_bitmask_dp_solver_top
// Self-checking testbench for the bitmask dynamic-programming tour solver.
// Weight matrices are loaded one word at a time. A local Held-Karp tour
// predictor computes the tour words that each solve must return. Every
// result word is checked field by field against the oldest predicted word.
// Both channels idle at random, and the receiver holds off for a long spell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tsp_bitmask_dp_solver_top;

  localparam int NV = tsp_pkg::MAX_V;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [3:0]  vertex;
    logic [19:0] cost;
    logic        found;
    logic        eot;
  } tour_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_row = '0;
  logic [3:0]  in_col = '0;
  logic [15:0] in_weight = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_vertex;
  logic [19:0] out_tour_cost;
  logic        out_found;
  logic        out_end_of_tour;

  tour_word_t tour_q[$];
  logic [16:0] weight_mirror[NV][NV];
  int          cost_cell[1 << NV][NV];
  bit          cost_ok[1 << NV][NV];
  int          pred_cell[1 << NV][NV];
  int          vcount_mirror = tsp_pkg::VC_RESET;
  int          mismatches = 0;
  int          cycles = 0;
  int          words_sent = 0;
  int          words_seen = 0;
  int          long_hold = 0;
  bit          idle_on = 1'b1;

  tsp_bitmask_dp_solver_top uut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_row(in_row), .in_col(in_col),
    .in_weight(in_weight), .in_last(in_last), .out_valid(out_valid),
    .out_stall(out_stall), .out_vertex(out_vertex), .out_tour_cost(out_tour_cost),
    .out_found(out_found), .out_end_of_tour(out_end_of_tour)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic solve_tour();
    int n, full, best, best_j, c, p, m, j;
    bit have;
    int tour[NV];
    tour_word_t t;
    n = (vcount_mirror < 1) ? 1 : (vcount_mirror > NV) ? NV : vcount_mirror;
    if (n == 1) begin
      t = '{4'd0, 20'd0, 1'b1, 1'b1};
      tour_q.push_back(t);
      return;
    end
    full = (1 << n) - 1;
    for (int mask = 1; mask <= full; mask += 2) begin
      for (int jj = 0; jj < n; jj++) begin
        cost_ok[mask][jj] = 0;
        cost_cell[mask][jj] = 0;
        pred_cell[mask][jj] = 0;
        if (jj == 0) begin
          if (mask == 1) cost_ok[mask][jj] = 1;
        end else if (mask[jj]) begin
          m = mask & ~(1 << jj);
          for (int k = 0; k < n; k++) begin
            if (m[k] && cost_ok[m][k] && k != jj && weight_mirror[k][jj] != 0) begin
              c = cost_cell[m][k] + weight_mirror[k][jj];
              if (!cost_ok[mask][jj] || c < cost_cell[mask][jj]) begin
                cost_ok[mask][jj] = 1;
                cost_cell[mask][jj] = c;
                pred_cell[mask][jj] = k;
              end
            end
          end
        end
      end
    end
    have = 0;
    best = 0;
    best_j = 0;
    for (int jj = 1; jj < n; jj++) begin
      if (cost_ok[full][jj] && weight_mirror[jj][0] != 0) begin
        c = cost_cell[full][jj] + weight_mirror[jj][0];
        if (!have || c < best) begin
          have = 1;
          best = c;
          best_j = jj;
        end
      end
    end
    if (!have) begin
      t = '{4'd0, 20'd0, 1'b0, 1'b1};
      tour_q.push_back(t);
      return;
    end
    m = full;
    j = best_j;
    for (int pos = n - 1; pos > 0; pos--) begin
      p = pred_cell[m][j];
      tour[pos] = j;
      m = m & ~(1 << j);
      j = p;
    end
    tour[0] = 0;
    for (int pos = 0; pos < n; pos++) begin
      t.vertex = 4'(tour[pos]);
      t.cost = best[19:0];
      t.found = 1'b1;
      t.eot = (pos == n - 1);
      tour_q.push_back(t);
    end
  endtask

  always @(posedge clk) begin
    tour_word_t t;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (tour_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: vertex %0d", out_vertex);
      end else begin
        t = tour_q.pop_front();
        if (out_vertex !== t.vertex || out_tour_cost !== t.cost ||
            out_found !== t.found || out_end_of_tour !== t.eot) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected v=%0d c=%0d f=%0d e=%0d, got v=%0d c=%0d f=%0d e=%0d",
                     t.vertex, t.cost, t.found, t.eot, out_vertex, out_tour_cost,
                     out_found, out_end_of_tour);
        end
      end
    end
  end

  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall = 1'b1;
        long_hold--;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(0, 13);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_word(input logic [3:0] r, input logic [3:0] c,
                           input logic [15:0] w, input logic l);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_row = r;
    in_col = c;
    in_weight = w;
    in_last = l;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r < NV && c < NV) begin
      weight_mirror[r][c] = {1'b0, w};
      words_sent++;
    end
    if (l) solve_tour();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (tour_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_vcount(input logic [3:0] v);
    wait_drained();
    cfg_wr_data = v;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    vcount_mirror = v;
  endtask

  function automatic logic [15:0] pick_weight(input int style);
    unique case (style)
      0: return 16'($urandom_range(1, 65535));
      1: return 16'($urandom_range(1, 3));
      2: return ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 300));
      default: return ($urandom_range(0, 4) != 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic send_matrix(input int n, input int style, input bit noise);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (noise && $urandom_range(0, 7) == 0)
          send_word(4'($urandom_range(12, 15)), 4'($urandom_range(0, 15)),
                    16'($urandom), 1'b0);
        send_word(4'(r), 4'(c), pick_weight(style), (r == n - 1) && (c == n - 1));
      end
    end
  endtask

  task automatic test_reset_vcount();
    send_matrix(4, 0, 0);
    send_word(4'd3, 4'd0, 16'hFFFF, 1'b1);
  endtask

  task automatic test_single_vertex();
    write_vcount(4'd1);
    send_word(4'd0, 4'd0, 16'h0000, 1'b1);
    write_vcount(4'd0);
    send_word(4'd0, 4'd0, 16'hFFFF, 1'b1);
  endtask

  task automatic test_two_vertex();
    write_vcount(4'd2);
    send_word(4'd0, 4'd1, 16'h8000, 1'b0);
    send_word(4'd1, 4'd0, 16'h7FFF, 1'b0);
    send_word(4'd1, 4'd1, 16'h1234, 1'b0);
    send_word(4'd0, 4'd0, 16'h0000, 1'b1);
    send_word(4'd1, 4'd0, 16'h0000, 1'b1);
  endtask

  task automatic test_ignored_entries();
    write_vcount(4'd2);
    send_word(4'd12, 4'd0, 16'hAAAA, 1'b0);
    send_word(4'd0, 4'd15, 16'h5555, 1'b0);
    send_word(4'd1, 4'd0, 16'h0001, 1'b1);
  endtask

  task automatic test_ties();
    write_vcount(4'd4);
    send_matrix(4, 1, 0);
  endtask

  task automatic test_backpressure();
    write_vcount(4'd3);
    long_hold = 600;
    send_matrix(3, 0, 0);
    send_matrix(3, 2, 0);
    send_matrix(3, 0, 0);
    wait_drained();
  endtask

  task automatic test_largest();
    write_vcount(4'd7);
    send_matrix(7, 0, 0);
  endtask

  task automatic test_random();
    int n, start;
    start = words_sent;
    while (words_sent - start < 24) begin
      if (words_sent - start > 8) idle_on = 1'b0;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 5) : $urandom_range(2, 3);
      write_vcount(4'(n));
      send_matrix(n, $urandom_range(0, 3), 1);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_reset_vcount();
    test_single_vertex();
    test_two_vertex();
    test_ignored_entries();
    test_ties();
    test_backpressure();
    test_largest();
    test_random();
    wait_drained();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && tour_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_ctrl.sv
hw/rtl/tsp_datapath.sv
hw/rtl/tsp_bitmask_dp_solver_top.sv
sim/tb_tsp_bitmask_dp_solver_top.sv
